@@ src/suffix_array_lcp_engine_defines.svh @@
// ----------------------------------------------------------------------------
// suffix array lcp engine assertion macros
// shared property forms for the engine's checks
// ----------------------------------------------------------------------------
`ifndef SUFFIX_ARRAY_LCP_ENGINE_DEFINES_SVH
`define SUFFIX_ARRAY_LCP_ENGINE_DEFINES_SVH

// same-cycle implication
`define SAL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sal_pkg.sv @@
// ----------------------------------------------------------------------------
// sal_pkg
// types, codes and defaults shared by the suffix array lcp engine
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int DEF_MAX_LEN     = 1024;
  localparam int DEF_SYMBOL_BITS = 16;
  localparam int FIELD_W         = 11;
  localparam int OP_W            = 2;
  localparam int SYM_W           = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_LCP  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_RANGE     = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_READ,
    KIND_LCP,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SYM_W-1:0]   symbol;
    logic               last;
    logic [FIELD_W-1:0] rank;
    logic [FIELD_W-1:0] pos_a;
    logic [FIELD_W-1:0] pos_b;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] suffix_start;
    logic [FIELD_W-1:0] lcp_value;
  } out_t;

  typedef struct packed {
    kind_t              kind;
    logic [SYM_W-1:0]   symbol;
    logic               last;
    logic [FIELD_W-1:0] rank;
    logic [FIELD_W-1:0] pos_a;
    logic [FIELD_W-1:0] pos_b;
    logic               same_pos;
  } req_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_RESP,
    S_Q_RD,
    S_Q_L1,
    S_Q_L2,
    S_Q_L3,
    S_Q_L4,
    S_B_INIT,
    S_INS,
    S_INS_P,
    S_INS_CHK,
    S_INS_A,
    S_INS_B,
    S_INS_PUT,
    S_RK0,
    S_RK,
    S_RK_A,
    S_RK_B,
    S_RK_SA,
    S_RK_SB,
    S_RK_CP,
    S_DBL,
    S_CPY,
    S_CPY_W,
    S_SC,
    S_SC_T,
    S_SC_C,
    S_SC_S,
    S_RR,
    S_RR_A,
    S_RR_B,
    S_RR_1,
    S_RR_2,
    S_RR_3,
    S_RR_4,
    S_RR_CP,
    S_K,
    S_K_R,
    S_K_A,
    S_K_CMP,
    S_K_S1,
    S_K_S2,
    S_K_WR,
    S_T,
    S_T_B,
    S_T_X,
    S_T_Y
  } state_t;

endpackage

@@ src/sal_front.sv @@
// ----------------------------------------------------------------------------
// sal_front
// request intake: registers each request and decodes its kind
// ----------------------------------------------------------------------------
module sal_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sal_pkg::in_t   req_data,
  output logic           q_valid,
  input  logic           q_stall,
  output sal_pkg::req_t  q_req
);

  logic          f_valid;
  sal_pkg::req_t f_req;
  sal_pkg::req_t dec;

  always_comb begin
    dec.symbol   = req_data.symbol;
    dec.last     = req_data.last;
    dec.rank     = req_data.rank;
    dec.pos_a    = req_data.pos_a;
    dec.pos_b    = req_data.pos_b;
    dec.same_pos = (req_data.pos_a == req_data.pos_b);
    case (req_data.op)
      sal_pkg::OP_LOAD: dec.kind = sal_pkg::KIND_LOAD;
      sal_pkg::OP_READ: dec.kind = sal_pkg::KIND_READ;
      sal_pkg::OP_LCP:  dec.kind = sal_pkg::KIND_LCP;
      default:          dec.kind = sal_pkg::KIND_BAD;
    endcase
  end

  assign req_stall = f_valid && q_stall;
  assign q_valid   = f_valid;
  assign q_req     = f_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!f_valid || !q_stall) begin
      f_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      f_req <= dec;
    end
  end

endmodule

@@ src/sal_queue.sv @@
// ----------------------------------------------------------------------------
// sal_queue
// short request queue between intake and execution
// ----------------------------------------------------------------------------
module sal_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sal_pkg::req_t  in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output sal_pkg::req_t  out_req
);

  localparam int QAW = $clog2(sal_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(sal_pkg::QUEUE_DEPTH + 1);

  sal_pkg::req_t  entries [sal_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;

  assign in_stall  = (count == QCW'(sal_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_req   = entries[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(sal_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(sal_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_req;
    end
  end

endmodule

@@ src/sal_back.sv @@
// ----------------------------------------------------------------------------
// sal_back
// execution: text store, suffix array build, lcp and range-minimum tables,
// query lookups and the response register
// ----------------------------------------------------------------------------
module sal_back #(
  parameter int MAX_LEN     = sal_pkg::DEF_MAX_LEN,
  parameter int SYMBOL_BITS = sal_pkg::DEF_SYMBOL_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_stall,
  input  sal_pkg::req_t  q_req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sal_pkg::out_t  rsp_data
);

  localparam int W        = $clog2(MAX_LEN + 2);
  localparam int AW       = $clog2(MAX_LEN + 1);
  localparam int SW       = $clog2(MAX_LEN);
  localparam int LEVELS   = SW + 1;
  localparam int LW       = $clog2(LEVELS);
  localparam int MW       = LW + SW;
  localparam int XW       = (W + 2 > sal_pkg::FIELD_W) ? W + 2 : sal_pkg::FIELD_W;
  localparam int MT_DEPTH = LEVELS << SW;
  localparam int FW       = sal_pkg::FIELD_W;
  localparam int SB       = SYMBOL_BITS;

  function automatic logic [LW-1:0] flog(input logic [W-1:0] v);
    logic [LW-1:0] d;
    d = '0;
    for (int k = 0; k < W; k++) begin
      if (v[k]) d = LW'(k);
    end
    return d;
  endfunction

  function automatic sal_pkg::out_t mk_rsp(input sal_pkg::status_e_t st,
                                           input logic [FW-1:0] start,
                                           input logic [FW-1:0] value);
    sal_pkg::out_t r;
    r.status       = st;
    r.suffix_start = start;
    r.lcp_value    = value;
    return r;
  endfunction

  // memories
  logic [SB-1:0] sym_mem  [MAX_LEN];
  logic [W-1:0]  sa_mem   [MAX_LEN + 1];
  logic [W-1:0]  rk_mem   [MAX_LEN + 1];
  logic [W-1:0]  wsa_mem  [MAX_LEN + 1];
  logic [W-1:0]  wrk_mem  [MAX_LEN + 1];
  logic [W-1:0]  slot_mem [MAX_LEN + 1];
  logic [W-1:0]  mt_mem   [MT_DEPTH];

  logic          sym_we, sa_we, rk_we, wsa_we, wrk_we, slot_we, mt_we;
  logic [SW-1:0] sym_wa, sym_ra;
  logic [AW-1:0] sa_wa, sa_ra, rk_wa, rk_ra, wsa_wa, wsa_ra;
  logic [AW-1:0] wrk_wa, wrk_ra, slot_wa, slot_ra;
  logic [MW-1:0] mt_wa, mt_ra;
  logic [SB-1:0] sym_wd, sym_rd;
  logic [W-1:0]  sa_wd, sa_rd, rk_wd, rk_rd, wsa_wd, wsa_rd;
  logic [W-1:0]  wrk_wd, wrk_rd, slot_wd, slot_rd, mt_wd, mt_rd;

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_wa] <= sym_wd;
    sym_rd <= sym_mem[sym_ra];
  end
  always_ff @(posedge clk) begin
    if (sa_we) sa_mem[sa_wa] <= sa_wd;
    sa_rd <= sa_mem[sa_ra];
  end
  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
    rk_rd <= rk_mem[rk_ra];
  end
  always_ff @(posedge clk) begin
    if (wsa_we) wsa_mem[wsa_wa] <= wsa_wd;
    wsa_rd <= wsa_mem[wsa_ra];
  end
  always_ff @(posedge clk) begin
    if (wrk_we) wrk_mem[wrk_wa] <= wrk_wd;
    wrk_rd <= wrk_mem[wrk_ra];
  end
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end
  always_ff @(posedge clk) begin
    if (mt_we) mt_mem[mt_wa] <= mt_wd;
    mt_rd <= mt_mem[mt_ra];
  end

  // control and working registers
  sal_pkg::state_t state, state_next;
  logic [W-1:0]    text_len, text_len_next;
  logic            table_ready, table_ready_next;
  logic            over, over_next;
  sal_pkg::req_t   cur, cur_next;
  sal_pkg::out_t   rsp, rsp_next;
  logic [W-1:0]    i, i_next;
  logic [W-1:0]    j, j_next;
  logic [W-1:0]    p, p_next;
  logic [W-1:0]    ta, ta_next;
  logic [W-1:0]    tb, tb_next;
  logic [W-1:0]    tx, tx_next;
  logic [W-1:0]    th, th_next;
  logic [W-1:0]    s, s_next;
  logic [W-1:0]    c, c_next;
  logic [W:0]      len, len_next;
  logic [LW:0]     lvl, lvl_next;
  logic [SB-1:0]   symx, symx_next;

  logic [W-1:0]    nl;
  logic [W-1:0]    cnt;
  logic [W-1:0]    q_lo;
  logic [W-1:0]    q_hi;
  logic [LW-1:0]   q_d;
  logic [XW-1:0]   rx, ax, bx, sx;

  assign nl   = table_ready ? '0 : text_len;
  assign cnt  = text_len + W'(1);
  assign q_lo = (tx < rk_rd) ? tx : rk_rd;
  assign q_hi = (tx < rk_rd) ? rk_rd : tx;
  assign q_d  = flog(q_hi - q_lo);
  assign rx   = XW'(q_req.rank);
  assign ax   = XW'(q_req.pos_a);
  assign bx   = XW'(q_req.pos_b);
  assign sx   = XW'(wsa_rd) - XW'(len);

  assign rsp_valid = (state == sal_pkg::S_RESP);
  assign rsp_data  = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sal_pkg::S_IDLE;
      text_len    <= '0;
      table_ready <= 1'b0;
    end else begin
      state       <= state_next;
      text_len    <= text_len_next;
      table_ready <= table_ready_next;
    end
  end

  always_ff @(posedge clk) begin
    over <= over_next;
    cur  <= cur_next;
    rsp  <= rsp_next;
    i    <= i_next;
    j    <= j_next;
    p    <= p_next;
    ta   <= ta_next;
    tb   <= tb_next;
    tx   <= tx_next;
    th   <= th_next;
    s    <= s_next;
    c    <= c_next;
    len  <= len_next;
    lvl  <= lvl_next;
    symx <= symx_next;
  end

  always_comb begin
    state_next       = state;
    text_len_next    = text_len;
    table_ready_next = table_ready;
    over_next        = over;
    cur_next         = cur;
    rsp_next         = rsp;
    i_next           = i;
    j_next           = j;
    p_next           = p;
    ta_next          = ta;
    tb_next          = tb;
    tx_next          = tx;
    th_next          = th;
    s_next           = s;
    c_next           = c;
    len_next         = len;
    lvl_next         = lvl;
    symx_next        = symx;
    q_stall          = 1'b1;
    sym_we  = 1'b0; sym_wa  = '0; sym_wd  = '0; sym_ra  = '0;
    sa_we   = 1'b0; sa_wa   = '0; sa_wd   = '0; sa_ra   = '0;
    rk_we   = 1'b0; rk_wa   = '0; rk_wd   = '0; rk_ra   = '0;
    wsa_we  = 1'b0; wsa_wa  = '0; wsa_wd  = '0; wsa_ra  = '0;
    wrk_we  = 1'b0; wrk_wa  = '0; wrk_wd  = '0; wrk_ra  = '0;
    slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;
    mt_we   = 1'b0; mt_wa   = '0; mt_wd   = '0; mt_ra   = '0;

    case (state)
      sal_pkg::S_IDLE: begin
        q_stall = 1'b0;
        if (q_valid) begin
          cur_next = q_req;
          case (q_req.kind)
            sal_pkg::KIND_LOAD: begin
              table_ready_next = 1'b0;
              if (XW'(nl) >= XW'(MAX_LEN)) begin
                over_next     = 1'b1;
                text_len_next = nl;
              end else begin
                over_next     = 1'b0;
                sym_we        = 1'b1;
                sym_wa        = SW'(nl);
                sym_wd        = SB'(q_req.symbol);
                text_len_next = nl + W'(1);
              end
              if (q_req.last) begin
                state_next = sal_pkg::S_B_INIT;
              end else if (XW'(nl) >= XW'(MAX_LEN)) begin
                rsp_next   = mk_rsp(sal_pkg::ST_RANGE, '0, '0);
                state_next = sal_pkg::S_RESP;
              end
            end
            sal_pkg::KIND_READ: begin
              if (!table_ready) begin
                rsp_next   = mk_rsp(sal_pkg::ST_NOT_BUILT, '0, '0);
                state_next = sal_pkg::S_RESP;
              end else if (rx > XW'(text_len)) begin
                rsp_next   = mk_rsp(sal_pkg::ST_RANGE, '0, '0);
                state_next = sal_pkg::S_RESP;
              end else begin
                sa_ra      = AW'(rx);
                mt_ra      = {LW'(0), SW'(rx - XW'(1))};
                state_next = sal_pkg::S_Q_RD;
              end
            end
            sal_pkg::KIND_LCP: begin
              if (!table_ready) begin
                rsp_next   = mk_rsp(sal_pkg::ST_NOT_BUILT, '0, '0);
                state_next = sal_pkg::S_RESP;
              end else if (ax > XW'(text_len) || bx > XW'(text_len)) begin
                rsp_next   = mk_rsp(sal_pkg::ST_RANGE, '0, '0);
                state_next = sal_pkg::S_RESP;
              end else if (q_req.same_pos) begin
                rsp_next   = mk_rsp(sal_pkg::ST_OK, '0, FW'(XW'(text_len) - ax));
                state_next = sal_pkg::S_RESP;
              end else begin
                rk_ra      = AW'(ax);
                state_next = sal_pkg::S_Q_L1;
              end
            end
            default: begin
              rsp_next   = mk_rsp(sal_pkg::ST_RANGE, '0, '0);
              state_next = sal_pkg::S_RESP;
            end
          endcase
        end
      end

      sal_pkg::S_RESP: begin
        if (!rsp_stall) state_next = sal_pkg::S_IDLE;
      end

      // rank read
      sal_pkg::S_Q_RD: begin
        rsp_next = mk_rsp(sal_pkg::ST_OK, FW'(sa_rd),
                          (cur.rank == '0) ? '0 : FW'(mt_rd));
        state_next = sal_pkg::S_RESP;
      end

      // lcp of two positions
      sal_pkg::S_Q_L1: begin
        tx_next    = rk_rd;
        rk_ra      = AW'(XW'(cur.pos_b));
        state_next = sal_pkg::S_Q_L2;
      end
      sal_pkg::S_Q_L2: begin
        if (q_lo < q_hi && XW'(q_hi) - XW'(1) < XW'(text_len)) begin
          tb_next    = q_hi;
          lvl_next   = (LW + 1)'(q_d);
          mt_ra      = {q_d, SW'(q_lo)};
          state_next = sal_pkg::S_Q_L3;
        end else begin
          rsp_next   = mk_rsp(sal_pkg::ST_OK, '0, '0);
          state_next = sal_pkg::S_RESP;
        end
      end
      sal_pkg::S_Q_L3: begin
        tx_next    = mt_rd;
        mt_ra      = {LW'(lvl), SW'(XW'(tb) - (XW'(1) << lvl))};
        state_next = sal_pkg::S_Q_L4;
      end
      sal_pkg::S_Q_L4: begin
        rsp_next   = mk_rsp(sal_pkg::ST_OK, '0, FW'((tx < mt_rd) ? tx : mt_rd));
        state_next = sal_pkg::S_RESP;
      end

      // insertion sort by first symbol, empty suffix at rank 0
      sal_pkg::S_B_INIT: begin
        sa_we      = 1'b1;
        sa_wa      = '0;
        sa_wd      = text_len;
        i_next     = '0;
        state_next = sal_pkg::S_INS;
      end
      sal_pkg::S_INS: begin
        if (i < text_len) begin
          j_next     = i + W'(1);
          p_next     = i;
          sym_ra     = SW'(i);
          state_next = sal_pkg::S_INS_P;
        end else begin
          state_next = sal_pkg::S_RK0;
        end
      end
      sal_pkg::S_INS_P: begin
        symx_next  = sym_rd;
        state_next = sal_pkg::S_INS_CHK;
      end
      sal_pkg::S_INS_CHK: begin
        if (j > W'(1)) begin
          sa_ra      = AW'(j - W'(1));
          state_next = sal_pkg::S_INS_A;
        end else begin
          state_next = sal_pkg::S_INS_PUT;
        end
      end
      sal_pkg::S_INS_A: begin
        ta_next    = sa_rd;
        sym_ra     = SW'(sa_rd);
        state_next = sal_pkg::S_INS_B;
      end
      sal_pkg::S_INS_B: begin
        if (sym_rd > symx) begin
          sa_we      = 1'b1;
          sa_wa      = AW'(j);
          sa_wd      = ta;
          j_next     = j - W'(1);
          state_next = sal_pkg::S_INS_CHK;
        end else begin
          state_next = sal_pkg::S_INS_PUT;
        end
      end
      sal_pkg::S_INS_PUT: begin
        sa_we      = 1'b1;
        sa_wa      = AW'(j);
        sa_wd      = p;
        i_next     = i + W'(1);
        state_next = sal_pkg::S_INS;
      end

      // first ranks
      sal_pkg::S_RK0: begin
        rk_we      = 1'b1;
        rk_wa      = AW'(text_len);
        rk_wd      = '0;
        i_next     = W'(1);
        state_next = sal_pkg::S_RK;
      end
      sal_pkg::S_RK: begin
        if (i < cnt) begin
          sa_ra      = AW'(i - W'(1));
          state_next = sal_pkg::S_RK_A;
        end else begin
          len_next   = (W + 1)'(1);
          state_next = sal_pkg::S_DBL;
        end
      end
      sal_pkg::S_RK_A: begin
        ta_next    = sa_rd;
        sa_ra      = AW'(i);
        state_next = sal_pkg::S_RK_B;
      end
      sal_pkg::S_RK_B: begin
        tb_next = sa_rd;
        if (i > W'(1)) begin
          sym_ra     = SW'(ta);
          state_next = sal_pkg::S_RK_SA;
        end else begin
          rk_we      = 1'b1;
          rk_wa      = AW'(sa_rd);
          rk_wd      = i;
          i_next     = i + W'(1);
          state_next = sal_pkg::S_RK;
        end
      end
      sal_pkg::S_RK_SA: begin
        symx_next  = sym_rd;
        sym_ra     = SW'(tb);
        state_next = sal_pkg::S_RK_SB;
      end
      sal_pkg::S_RK_SB: begin
        if (symx == sym_rd) begin
          rk_ra      = AW'(ta);
          state_next = sal_pkg::S_RK_CP;
        end else begin
          rk_we      = 1'b1;
          rk_wa      = AW'(tb);
          rk_wd      = i;
          i_next     = i + W'(1);
          state_next = sal_pkg::S_RK;
        end
      end
      sal_pkg::S_RK_CP: begin
        rk_we      = 1'b1;
        rk_wa      = AW'(tb);
        rk_wd      = rk_rd;
        i_next     = i + W'(1);
        state_next = sal_pkg::S_RK;
      end

      // prefix doubling passes
      sal_pkg::S_DBL: begin
        i_next = '0;
        if (XW'(len) < XW'(cnt)) begin
          state_next = sal_pkg::S_CPY;
        end else begin
          th_next    = '0;
          state_next = sal_pkg::S_K;
        end
      end
      sal_pkg::S_CPY: begin
        if (i < cnt) begin
          sa_ra      = AW'(i);
          rk_ra      = AW'(i);
          state_next = sal_pkg::S_CPY_W;
        end else begin
          i_next     = '0;
          state_next = sal_pkg::S_SC;
        end
      end
      sal_pkg::S_CPY_W: begin
        wsa_we     = 1'b1;
        wsa_wa     = AW'(i);
        wsa_wd     = sa_rd;
        wrk_we     = 1'b1;
        wrk_wa     = AW'(i);
        wrk_wd     = rk_rd;
        slot_we    = 1'b1;
        slot_wa    = AW'(i);
        slot_wd    = i;
        i_next     = i + W'(1);
        state_next = sal_pkg::S_CPY;
      end
      sal_pkg::S_SC: begin
        if (i < cnt) begin
          wsa_ra     = AW'(i);
          state_next = sal_pkg::S_SC_T;
        end else begin
          i_next     = W'(1);
          state_next = sal_pkg::S_RR;
        end
      end
      sal_pkg::S_SC_T: begin
        if (XW'(wsa_rd) >= XW'(len)) begin
          s_next     = W'(sx);
          wrk_ra     = AW'(sx);
          state_next = sal_pkg::S_SC_C;
        end else begin
          i_next     = i + W'(1);
          state_next = sal_pkg::S_SC;
        end
      end
      sal_pkg::S_SC_C: begin
        c_next = wrk_rd;
        if (wrk_rd < cnt) begin
          slot_ra    = AW'(wrk_rd);
          state_next = sal_pkg::S_SC_S;
        end else begin
          i_next     = i + W'(1);
          state_next = sal_pkg::S_SC;
        end
      end
      sal_pkg::S_SC_S: begin
        if (slot_rd < cnt) begin
          sa_we   = 1'b1;
          sa_wa   = AW'(slot_rd);
          sa_wd   = s;
          slot_we = 1'b1;
          slot_wa = AW'(c);
          slot_wd = slot_rd + W'(1);
        end
        i_next     = i + W'(1);
        state_next = sal_pkg::S_SC;
      end
      sal_pkg::S_RR: begin
        if (i < cnt) begin
          sa_ra      = AW'(i - W'(1));
          state_next = sal_pkg::S_RR_A;
        end else begin
          len_next   = len << 1;
          state_next = sal_pkg::S_DBL;
        end
      end
      sal_pkg::S_RR_A: begin
        ta_next    = sa_rd;
        sa_ra      = AW'(i);
        state_next = sal_pkg::S_RR_B;
      end
      sal_pkg::S_RR_B: begin
        tb_next    = sa_rd;
        wrk_ra     = AW'(ta);
        state_next = sal_pkg::S_RR_1;
      end
      sal_pkg::S_RR_1: begin
        tx_next    = wrk_rd;
        wrk_ra     = AW'(tb);
        state_next = sal_pkg::S_RR_2;
      end
      sal_pkg::S_RR_2: begin
        if (tx == wrk_rd && XW'(ta) + XW'(len) <= XW'(text_len) &&
            XW'(tb) + XW'(len) <= XW'(text_len)) begin
          wrk_ra     = AW'(XW'(ta) + XW'(len));
          state_next = sal_pkg::S_RR_3;
        end else begin
          rk_we      = 1'b1;
          rk_wa      = AW'(tb);
          rk_wd      = i;
          i_next     = i + W'(1);
          state_next = sal_pkg::S_RR;
        end
      end
      sal_pkg::S_RR_3: begin
        tx_next    = wrk_rd;
        wrk_ra     = AW'(XW'(tb) + XW'(len));
        state_next = sal_pkg::S_RR_4;
      end
      sal_pkg::S_RR_4: begin
        if (tx == wrk_rd) begin
          rk_ra      = AW'(ta);
          state_next = sal_pkg::S_RR_CP;
        end else begin
          rk_we      = 1'b1;
          rk_wa      = AW'(tb);
          rk_wd      = i;
          i_next     = i + W'(1);
          state_next = sal_pkg::S_RR;
        end
      end
      sal_pkg::S_RR_CP: begin
        rk_we      = 1'b1;
        rk_wa      = AW'(tb);
        rk_wd      = rk_rd;
        i_next     = i + W'(1);
        state_next = sal_pkg::S_RR;
      end

      // kasai lcp into level 0 of the min table
      sal_pkg::S_K: begin
        if (i < text_len) begin
          rk_ra      = AW'(i);
          state_next = sal_pkg::S_K_R;
        end else begin
          lvl_next   = (LW + 1)'(1);
          state_next = sal_pkg::S_T;
        end
      end
      sal_pkg::S_K_R: begin
        tb_next = rk_rd;
        if (rk_rd == '0 || rk_rd > text_len) begin
          th_next    = '0;
          i_next     = i + W'(1);
          state_next = sal_pkg::S_K;
        end else begin
          sa_ra      = AW'(rk_rd - W'(1));
          state_next = sal_pkg::S_K_A;
        end
      end
      sal_pkg::S_K_A: begin
        ta_next    = sa_rd;
        state_next = sal_pkg::S_K_CMP;
      end
      sal_pkg::S_K_CMP: begin
        if (XW'(ta) + XW'(th) < XW'(text_len) && XW'(i) + XW'(th) < XW'(text_len)) begin
          sym_ra     = SW'(XW'(ta) + XW'(th));
          state_next = sal_pkg::S_K_S1;
        end else begin
          state_next = sal_pkg::S_K_WR;
        end
      end
      sal_pkg::S_K_S1: begin
        symx_next  = sym_rd;
        sym_ra     = SW'(XW'(i) + XW'(th));
        state_next = sal_pkg::S_K_S2;
      end
      sal_pkg::S_K_S2: begin
        if (symx == sym_rd) begin
          th_next    = th + W'(1);
          state_next = sal_pkg::S_K_CMP;
        end else begin
          state_next = sal_pkg::S_K_WR;
        end
      end
      sal_pkg::S_K_WR: begin
        mt_we = 1'b1;
        mt_wa = {LW'(0), SW'(tb - W'(1))};
        mt_wd = th;
        if (th != '0) th_next = th - W'(1);
        i_next     = i + W'(1);
        state_next = sal_pkg::S_K;
      end

      // sparse table levels
      sal_pkg::S_T: begin
        if (XW'(lvl) < XW'(LEVELS) && (XW'(1) << lvl) <= XW'(text_len)) begin
          i_next     = '0;
          state_next = sal_pkg::S_T_B;
        end else begin
          table_ready_next = 1'b1;
          rsp_next   = mk_rsp(over ? sal_pkg::ST_RANGE : sal_pkg::ST_OK, '0, '0);
          state_next = sal_pkg::S_RESP;
        end
      end
      sal_pkg::S_T_B: begin
        if (XW'(i) + (XW'(1) << lvl) <= XW'(text_len)) begin
          mt_ra      = {LW'(lvl - 1'b1), SW'(i)};
          state_next = sal_pkg::S_T_X;
        end else begin
          lvl_next   = lvl + 1'b1;
          state_next = sal_pkg::S_T;
        end
      end
      sal_pkg::S_T_X: begin
        tx_next    = mt_rd;
        mt_ra      = {LW'(lvl - 1'b1), SW'(XW'(i) + (XW'(1) << (lvl - 1'b1)))};
        state_next = sal_pkg::S_T_Y;
      end
      sal_pkg::S_T_Y: begin
        mt_we      = 1'b1;
        mt_wa      = {LW'(lvl), SW'(i)};
        mt_wd      = (tx < mt_rd) ? tx : mt_rd;
        i_next     = i + W'(1);
        state_next = sal_pkg::S_T_B;
      end

      default: begin
        state_next = sal_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/suffix_array_lcp_engine.sv @@
// ----------------------------------------------------------------------------
// suffix_array_lcp_engine
// suffix array, lcp array and range-minimum lookups over a loaded text
// ----------------------------------------------------------------------------
// A request passes an intake register and a four-entry queue, then one
// executor that works on a single request at a time and holds its response
// until taken. A plain load stores its symbol in the executor and gives no
// response unless the store is full. A final load runs the build on the
// executor's table memories, each with one read and one write port: an
// insertion sort, the first ranks, then each of the log2(n+1) (rounded up)
// doubling passes, the lcp array, and the sparse-table levels. Intake
// keeps accepting until the queue fills.
module suffix_array_lcp_engine #(
  parameter int MAX_LEN     = sal_pkg::DEF_MAX_LEN,
  parameter int SYMBOL_BITS = sal_pkg::DEF_SYMBOL_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sal_pkg::in_t  req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sal_pkg::out_t rsp_data
);

  `include "suffix_array_lcp_engine_defines.svh"

  logic          f_valid;
  logic          f_stall;
  sal_pkg::req_t f_req;
  logic          b_valid;
  logic          b_stall;
  sal_pkg::req_t b_req;

  sal_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .q_valid   (f_valid),
    .q_stall   (f_stall),
    .q_req     (f_req)
  );

  sal_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_req    (f_req),
    .out_valid (b_valid),
    .out_stall (b_stall),
    .out_req   (b_req)
  );

  sal_back #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_stall   (b_stall),
    .q_req     (b_req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  `SAL_ASSERT_IMPLY(a_no_pop_while_rsp, rsp_valid, !(b_valid && !b_stall), "request popped while response pending")
  `SAL_ASSERT_NEXT(a_front_holds, f_valid && f_stall, f_valid && $stable(f_req), "intake lost a held request")
  `SAL_ASSERT_NEXT(a_front_takes, req_valid && !req_stall, f_valid, "accepted request not registered")

endmodule
